FILE: sv/first_fit_page_run_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// first fit page run allocator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define FPRA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpra assertion failed");

// consequent checked in the cycle after the antecedent
`define FPRA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpra assertion failed");

`endif

FILE: sv/fpra_pkg.sv
// ----------------------------------------------------------------------------
// fpra_pkg
// sizes, codes and shared types of the page run allocator
// ----------------------------------------------------------------------------
package fpra_pkg;

   localparam int NUM_PAGES = 1024;
   localparam int WORD_BITS = 8;
   localparam int WORD_W    = $clog2(WORD_BITS);
   localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
   localparam int WADDR_W   = $clog2(NUM_WORDS);
   localparam int PAGE_W    = $clog2(NUM_PAGES);
   localparam int CNT_W     = PAGE_W + 1;
   localparam int FRAME_W   = 32;
   localparam int FLAGS_W   = 8;
   localparam int STATUS_W  = 2;

   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MAPPED   = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_IGNORED  = 2'd2,
      STATUS_UNMAPPED = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_MAP   = 1'b0,
      FUNC_UNMAP = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RMW,
      ST_RESP
   } state_type;

   // free run being tracked by the first-fit scan
   typedef struct packed {
      logic [CNT_W-1:0] start;
      logic [CNT_W-1:0] len;
   } run_type;

endpackage

FILE: sv/first_fit_page_run_allocator_core.sv
// map: scans bitmap words from the one holding the hint, then writes the words of the run; a
//    map with no fit replies after the scan, unmap writes its words, rejected requests go straight to the reply
// requests: one in flight, the next is taken only after the reply is loaded; the ram
//    moves one bitmap word per cycle in both the scan and the read-modify-write pass
// reset: synchronous; a clearing pass over the 128 bitmap words zeroes the bitmap, req_stall high
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_core
// first-fit page run allocator over a used-page bitmap held in a word ram
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [fpra_pkg::PAGE_W-1:0]   req_page_index,
   input  logic [fpra_pkg::CNT_W-1:0]    req_page_count,
   input  logic [fpra_pkg::FRAME_W-1:0]  req_frame,
   input  logic [fpra_pkg::FLAGS_W-1:0]  req_map_flags,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fpra_pkg::STATUS_W-1:0] rsp_status,
   output logic [fpra_pkg::PAGE_W-1:0]   rsp_base_page,
   output logic [fpra_pkg::FRAME_W-1:0]  rsp_out_frame,
   output logic [fpra_pkg::FLAGS_W-1:0]  rsp_out_flags
);
   import fpra_pkg::*;

   // bitmap ram, one bit per page, registered read
   logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [WADDR_W-1:0]   mem_wa;
   logic [WORD_BITS-1:0] mem_wd;

   // control state
   state_type          state_ff, state_in;
   logic [WADDR_W-1:0] addr_ff, addr_in;          // word read issued this cycle
   logic [WADDR_W-1:0] data_addr_ff, data_addr_in; // word whose data is in rd_data_ff
   logic               data_vld_ff, data_vld_in;
   logic [CNT_W-1:0]   hint_ff, hint_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // request and result payload
   run_type              run_ff, run_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PAGE_W-1:0]    lo_ff, lo_in;
   logic [PAGE_W-1:0]    hi_ff, hi_in;
   logic                 set_ff, set_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [FLAGS_W-1:0]   flags_ff, flags_in;
   status_type           res_status_ff, res_status_in;
   logic [PAGE_W-1:0]    res_base_ff, res_base_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]    rsp_base_ff, rsp_base_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic [FLAGS_W-1:0]   rsp_flags_ff, rsp_flags_in;

   // decode of the incoming request
   logic               req_accept;
   logic [CNT_W:0]     unmap_end;
   logic               unmap_outside;
   logic [CNT_W-1:0]   map_room;
   logic               map_reject;
   logic               out_free;
   logic               out_load;

   // scan unit results
   run_type            scan_run;
   logic               scan_found;
   logic [CNT_W-1:0]   scan_start;
   logic [CNT_W-1:0]   scan_end;
   logic [WORD_BITS-1:0] run_mask;

   assign req_accept    = req_valid && !req_stall;
   assign unmap_end     = (CNT_W+1)'(req_page_index) + (CNT_W+1)'(req_page_count);
   assign unmap_outside = unmap_end > (CNT_W+1)'(NUM_PAGES);
   assign map_room      = CNT_W'(NUM_PAGES) - hint_ff;
   assign map_reject    = (req_page_count == '0) || (req_page_count > map_room);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign scan_end      = scan_start + count_ff;

   fpra_word_scan u_word_scan (
      .word        (rd_data_ff),
      .waddr       (data_addr_ff),
      .hint        (hint_ff),
      .count       (count_ff),
      .run_i       (run_ff),
      .run_o       (scan_run),
      .found       (scan_found),
      .found_start (scan_start)
   );

   // bits of the current word that fall inside the run [lo, hi]
   always_comb begin
      logic [PAGE_W-1:0] pos;
      pos = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         pos         = {data_addr_ff, WORD_W'(b)};
         run_mask[b] = (pos >= lo_ff) && (pos <= hi_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST_WORD) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_func == FUNC_MAP) begin
                  state_in = map_reject ? ST_RESP : ST_SCAN;
               end else begin
                  state_in = (unmap_outside || (req_page_count == '0)) ? ST_RESP : ST_RMW;
               end
            end
         end
         ST_SCAN: begin
            if (data_vld_ff) begin
               if (scan_found) begin
                  state_in = ST_RMW;
               end else if (data_addr_ff == LAST_WORD) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RMW: begin
            // last word of the run written
            if (data_vld_ff && (data_addr_ff == hi_ff[PAGE_W-1:WORD_W])) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshake and bitmap write port
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_wa    = data_addr_ff;
      mem_wd    = '0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_RMW: begin
            // set bits for a map, clear them for an unmap
            mem_we = data_vld_ff;
            mem_wd = set_ff ? (rd_data_ff | run_mask) : (rd_data_ff & ~run_mask);
         end
         ST_RESP: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      addr_in       = addr_ff;
      data_addr_in  = addr_ff;
      data_vld_in   = ((state_ff == ST_SCAN) || (state_ff == ST_RMW)) && (state_in == state_ff);
      hint_in       = hint_ff;
      run_in        = run_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      set_in        = set_ff;
      frame_in      = frame_ff;
      flags_in      = flags_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + WADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               count_in    = req_page_count;
               frame_in    = req_frame;
               flags_in    = req_map_flags;
               res_base_in = '0;
               if (req_func == FUNC_MAP) begin
                  set_in        = 1'b1;
                  res_status_in = STATUS_NO_SPACE;
                  // scan starts at the word holding the hint
                  addr_in       = hint_ff[PAGE_W-1:WORD_W];
                  run_in.start  = hint_ff;
                  run_in.len    = '0;
               end else begin
                  set_in        = 1'b0;
                  res_status_in = unmap_outside ? STATUS_IGNORED : STATUS_UNMAPPED;
                  lo_in         = req_page_index;
                  hi_in         = PAGE_W'(unmap_end - (CNT_W+1)'(1));
                  addr_in       = req_page_index[PAGE_W-1:WORD_W];
                  // freed pages pull the hint down
                  if (!unmap_outside && (CNT_W'(req_page_index) < hint_ff)) begin
                     hint_in = CNT_W'(req_page_index);
                  end
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + WADDR_W'(1);
            if (data_vld_ff) begin
               run_in = scan_run;
               if (scan_found) begin
                  res_status_in = STATUS_MAPPED;
                  res_base_in   = scan_start[PAGE_W-1:0];
                  lo_in         = scan_start[PAGE_W-1:0];
                  hi_in         = PAGE_W'(scan_end - CNT_W'(1));
                  hint_in       = scan_end;
                  addr_in       = scan_start[PAGE_W-1:WORD_W];
               end
            end
         end
         ST_RMW: begin
            addr_in = addr_ff + WADDR_W'(1);
         end
         default: ;
      endcase
   end

   // response register, filled only when the output side is free
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_flags_in  = rsp_flags_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         if (res_status_ff == STATUS_MAPPED) begin
            rsp_base_in  = res_base_ff;
            rsp_frame_in = frame_ff;
            rsp_flags_in = flags_ff;
         end else begin
            rsp_base_in  = '0;
            rsp_frame_in = '0;
            rsp_flags_in = '0;
         end
      end
   end

   // bitmap ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= bitmap_mem[addr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         data_addr_ff <= '0;
         data_vld_ff  <= 1'b0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         data_addr_ff <= data_addr_in;
         data_vld_ff  <= data_vld_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_ff        <= run_in;
      count_ff      <= count_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      set_ff        <= set_in;
      frame_ff      <= frame_in;
      flags_ff      <= flags_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_flags_ff  <= rsp_flags_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_base_page = rsp_base_ff;
   assign rsp_out_frame = rsp_frame_ff;
   assign rsp_out_flags = rsp_flags_ff;

endmodule

FILE: sv/fpra_word_scan.sv
// ----------------------------------------------------------------------------
// fpra_word_scan
// extends the tracked free run across one bitmap word
// ----------------------------------------------------------------------------
module fpra_word_scan (
   input  logic [fpra_pkg::WORD_BITS-1:0] word,
   input  logic [fpra_pkg::WADDR_W-1:0]   waddr,
   input  logic [fpra_pkg::CNT_W-1:0]     hint,
   input  logic [fpra_pkg::CNT_W-1:0]     count,
   input  fpra_pkg::run_type              run_i,
   output fpra_pkg::run_type              run_o,
   output logic                           found,
   output logic [fpra_pkg::CNT_W-1:0]     found_start
);
   import fpra_pkg::*;

   always_comb begin
      run_type          run_v;
      logic [CNT_W-1:0] pos;
      run_v       = run_i;
      found       = 1'b0;
      found_start = run_i.start;
      pos         = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         pos = CNT_W'({waddr, WORD_W'(b)});
         // pages below the hint are outside the search
         if (!found && (pos >= hint)) begin
            if (word[b]) begin
               run_v.len   = '0;
               run_v.start = pos + CNT_W'(1);
            end else begin
               run_v.len = run_v.len + CNT_W'(1);
               if (run_v.len == count) begin
                  found       = 1'b1;
                  found_start = run_v.start;
               end
            end
         end
      end
      run_o = run_v;
   end

endmodule

FILE: sv/fpra_checker.sv
// ----------------------------------------------------------------------------
// fpra_checker
// port-level checks of the page run allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "first_fit_page_run_allocator_core_defines.svh"

module fpra_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_func,
   input logic [fpra_pkg::PAGE_W-1:0]   req_page_index,
   input logic [fpra_pkg::CNT_W-1:0]    req_page_count,
   input logic [fpra_pkg::FRAME_W-1:0]  req_frame,
   input logic [fpra_pkg::FLAGS_W-1:0]  req_map_flags,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [fpra_pkg::STATUS_W-1:0] rsp_status,
   input logic [fpra_pkg::PAGE_W-1:0]   rsp_base_page,
   input logic [fpra_pkg::FRAME_W-1:0]  rsp_out_frame,
   input logic [fpra_pkg::FLAGS_W-1:0]  rsp_out_flags
);
   import fpra_pkg::*;

   // a stalled response holds
   `FPRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_base_page) && $stable(rsp_out_frame) && $stable(rsp_out_flags))

   // anything but a successful map carries no mapping command
   `FPRA_ASSERT_SAME(a_reject_zero, clock, reset, rsp_valid && (rsp_status != STATUS_MAPPED), (rsp_base_page == '0) && (rsp_out_frame == '0) && (rsp_out_flags == '0))

   // one request in flight: busy right after an accept
   `FPRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // bitmap clearing pass blocks requests after reset
   `FPRA_ASSERT_SAME(a_clear_after_reset, clock, reset, $past(reset), req_stall)

endmodule

bind first_fit_page_run_allocator_core fpra_checker u_fpra_checker (.*);
